// File: hdl/isbdc_pkg.sv
// ----------------------------------------------------------------------------
// isbdc_pkg
// Shared types, widths, register map and helpers for the IMU sample
// conditioner (gyro bias calibration, rate deadband, accel and temperature).
// ----------------------------------------------------------------------------
package isbdc_pkg;

	// Axis count and calibration length (must be a power of two)
	localparam int NAXES       = 3;
	localparam int CAL_SAMPLES = 1024;
	localparam int CAL_LOG2    = $clog2(CAL_SAMPLES);
	localparam int CNT_W       = (CAL_LOG2 > 0) ? CAL_LOG2 : 1;

	// Datapath widths
	localparam int RAW_W    = 16;
	localparam int BIAS_W   = 25;	// Q16.8 bias
	localparam int SUM_W    = 26;	// wrapping calibration sum
	localparam int D_W      = 26;	// raw*256 - bias
	localparam int SCALE_W  = 32;
	localparam int DB_W     = 31;
	localparam int TFAC_W   = 24;
	localparam int TOFS_W   = 24;
	localparam int TRAW_W   = 11;
	localparam int ID_W     = 8;
	localparam int OUT_W    = 32;
	localparam int GPROD_W  = D_W + SCALE_W + 1;
	localparam int APROD_W  = RAW_W + SCALE_W + 1;
	localparam int TPROD_W  = TRAW_W + TFAC_W + 1;
	localparam int SAT_IN_W = 37;
	localparam int GY_SHIFT = 24;
	localparam int AC_SHIFT = 16;

	// Configuration port
	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	typedef enum logic [2:0] {
		REG_GYRO_SCALE  = 3'd0,
		REG_ACCEL_SCALE = 3'd1,
		REG_RATE_DB     = 3'd2,
		REG_TEMP_FACTOR = 3'd3,
		REG_TEMP_OFFSET = 3'd4,
		REG_EXPECTED_ID = 3'd5
	} reg_idx_t;

	// Reset values
	localparam logic [SCALE_W-1:0]       GYRO_SCALE_RST  = SCALE_W'(4575271);
	localparam logic [SCALE_W-1:0]       ACCEL_SCALE_RST = SCALE_W'(3854136);
	localparam logic [DB_W-1:0]          RATE_DB_RST     = '0;
	localparam logic [TFAC_W-1:0]        TEMP_FACTOR_RST = TFAC_W'(8192);
	localparam logic signed [TOFS_W-1:0] TEMP_OFFSET_RST = TOFS_W'(1507328);
	localparam logic [ID_W-1:0]          EXPECTED_ID_RST = ID_W'(15);

	typedef logic signed [RAW_W-1:0]  raw_t;
	typedef logic signed [BIAS_W-1:0] bias_t;
	typedef logic signed [D_W-1:0]    diff_t;
	typedef logic signed [OUT_W-1:0]  fix_t;

	// Live configuration, handed from the register block to the datapath
	typedef struct packed {
		logic [SCALE_W-1:0]       gyro_scale;
		logic [SCALE_W-1:0]       accel_scale;
		logic [DB_W-1:0]          rate_deadband;
		logic [TFAC_W-1:0]        temp_factor;
		logic signed [TOFS_W-1:0] temp_offset;
		logic [ID_W-1:0]          expected_id;
	} cfg_t;

	// Clamp a wide signed value into 32-bit signed range
	function automatic fix_t sat32(input logic signed [SAT_IN_W-1:0] v);
		logic signed [SAT_IN_W-1:0] hi;
		logic signed [SAT_IN_W-1:0] lo;
		hi = SAT_IN_W'(fix_t'({1'b0, {(OUT_W-1){1'b1}}}));
		lo = SAT_IN_W'(fix_t'({1'b1, {(OUT_W-1){1'b0}}}));
		if (v > hi) begin
			return hi[OUT_W-1:0];
		end else if (v < lo) begin
			return lo[OUT_W-1:0];
		end
		return v[OUT_W-1:0];
	endfunction

endpackage

// File: hdl/isbdc_regs.sv
// ----------------------------------------------------------------------------
// isbdc_regs
// APB-style configuration registers; write on the access phase, reads are
// combinational from the stored fields.
// ----------------------------------------------------------------------------
module isbdc_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [isbdc_pkg::ADDR_W-1:0]  paddr,
	input  logic [isbdc_pkg::DATA_W-1:0]  pwdata,
	output logic [isbdc_pkg::DATA_W-1:0]  prdata,
	output isbdc_pkg::cfg_t               cfg
);
	import isbdc_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx   = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign wr_en = psel && penable && pwrite;
	assign cfg   = cfg_q;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gyro_scale    <= GYRO_SCALE_RST;
			cfg_q.accel_scale   <= ACCEL_SCALE_RST;
			cfg_q.rate_deadband <= RATE_DB_RST;
			cfg_q.temp_factor   <= TEMP_FACTOR_RST;
			cfg_q.temp_offset   <= TEMP_OFFSET_RST;
			cfg_q.expected_id   <= EXPECTED_ID_RST;
		end else if (wr_en) begin
			unique case (idx)
				REG_GYRO_SCALE:  cfg_q.gyro_scale    <= pwdata[SCALE_W-1:0];
				REG_ACCEL_SCALE: cfg_q.accel_scale   <= pwdata[SCALE_W-1:0];
				REG_RATE_DB:     cfg_q.rate_deadband <= pwdata[DB_W-1:0];
				REG_TEMP_FACTOR: cfg_q.temp_factor   <= pwdata[TFAC_W-1:0];
				REG_TEMP_OFFSET: cfg_q.temp_offset   <= pwdata[TOFS_W-1:0];
				REG_EXPECTED_ID: cfg_q.expected_id   <= pwdata[ID_W-1:0];
				default: ;	// unmapped address, write dropped
			endcase
		end
	end

	// Read mux
	always_comb begin
		prdata = '0;
		unique case (idx)
			REG_GYRO_SCALE:  prdata = DATA_W'(cfg_q.gyro_scale);
			REG_ACCEL_SCALE: prdata = DATA_W'(cfg_q.accel_scale);
			REG_RATE_DB:     prdata = DATA_W'(cfg_q.rate_deadband);
			REG_TEMP_FACTOR: prdata = DATA_W'(cfg_q.temp_factor);
			REG_TEMP_OFFSET: prdata = DATA_W'(unsigned'(cfg_q.temp_offset));
			REG_EXPECTED_ID: prdata = DATA_W'(cfg_q.expected_id);
			default:         prdata = '0;
		endcase
	end

endmodule

// File: hdl/isbdc_cal.sv
// ----------------------------------------------------------------------------
// isbdc_cal
// Gyro bias calibration: per-axis wrapping sums over a fixed number of
// calibration samples, then the mean stored as a Q16.8 bias.
// ----------------------------------------------------------------------------
module isbdc_cal (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              take,
	input  isbdc_pkg::raw_t   gyro [isbdc_pkg::NAXES],
	output isbdc_pkg::bias_t  bias [isbdc_pkg::NAXES],
	output logic              done
);
	import isbdc_pkg::*;

	logic signed [SUM_W-1:0] sum_q    [NAXES];
	logic signed [SUM_W-1:0] sum_next [NAXES];
	bias_t                   bias_q   [NAXES];
	bias_t                   mean     [NAXES];
	logic [CNT_W-1:0]        cnt_q;

	// Last sample of a calibration run completes it
	assign done = take && (cnt_q == CNT_W'(CAL_SAMPLES - 1));

	// Running sums and floor of sum*256/CAL_SAMPLES (a shift)
	always_comb begin
		for (int i = 0; i < NAXES; i++) begin
			sum_next[i] = sum_q[i] + SUM_W'(gyro[i]);
			mean[i]     = BIAS_W'(($signed({sum_next[i], 8'b0})) >>> CAL_LOG2);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			for (int i = 0; i < NAXES; i++) begin
				sum_q[i]  <= '0;
				bias_q[i] <= '0;
			end
		end else if (take) begin
			if (done) begin
				cnt_q <= '0;
				for (int i = 0; i < NAXES; i++) begin
					sum_q[i]  <= '0;
					bias_q[i] <= mean[i];
				end
			end else begin
				cnt_q <= cnt_q + 1'b1;
				for (int i = 0; i < NAXES; i++) begin
					sum_q[i] <= sum_next[i];
				end
			end
		end
	end

	assign bias = bias_q;

endmodule

// File: hdl/isbdc_gyro_lane.sv
// ----------------------------------------------------------------------------
// isbdc_gyro_lane
// One gyro axis: multiply by the gyro scale, round to Q15.16, saturate,
// apply the deadband and keep the last fresh rate for held outputs.
// ----------------------------------------------------------------------------
module isbdc_gyro_lane (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         ld_s2,
	input  logic                         ld_s3,
	input  isbdc_pkg::diff_t             diff_s1,
	input  logic [isbdc_pkg::SCALE_W-1:0] scale,
	input  logic [isbdc_pkg::DB_W-1:0]   deadband,
	input  logic                         fresh_s2,
	output isbdc_pkg::fix_t              rate_s3
);
	import isbdc_pkg::*;

	localparam logic signed [GPROD_W-1:0] GY_HALF = GPROD_W'(1) << (GY_SHIFT - 1);

	logic signed [GPROD_W-1:0] prod_s2;
	logic signed [GPROD_W-1:0] rnd_w;
	fix_t                      rate_c;
	fix_t                      db_s;
	fix_t                      held_q;
	fix_t                      rate_q_s3;
	logic                      in_band;

	// Stage 2: product
	always_ff @(posedge clk) begin
		if (ld_s2) begin
			prod_s2 <= GPROD_W'(diff_s1) * $signed({1'b0, scale});
		end
	end

	// Round, saturate, deadband
	always_comb begin
		rnd_w   = (prod_s2 + GY_HALF) >>> GY_SHIFT;
		rate_c  = sat32(SAT_IN_W'(rnd_w));
		db_s    = $signed({1'b0, deadband});
		in_band = (rate_c < db_s) && (rate_c > -db_s);
		if (in_band) begin
			rate_c = '0;
		end
	end

	// Stage 3: fresh rate or the last fresh one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
		end else if (ld_s3 && fresh_s2) begin
			held_q <= rate_c;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_s3) begin
			rate_q_s3 <= fresh_s2 ? rate_c : held_q;
		end
	end

	assign rate_s3 = rate_q_s3;

endmodule

// File: hdl/isbdc_accel_lane.sv
// ----------------------------------------------------------------------------
// isbdc_accel_lane
// One accel axis: multiply by the accel scale, round to Q15.16, saturate.
// ----------------------------------------------------------------------------
module isbdc_accel_lane (
	input  logic                          clk,
	input  logic                          ld_s2,
	input  logic                          ld_s3,
	input  isbdc_pkg::raw_t               raw_s1,
	input  logic [isbdc_pkg::SCALE_W-1:0] scale,
	output isbdc_pkg::fix_t               accel_s3
);
	import isbdc_pkg::*;

	localparam logic signed [APROD_W-1:0] AC_HALF = APROD_W'(1) << (AC_SHIFT - 1);

	logic signed [APROD_W-1:0] prod_s2;
	logic signed [APROD_W-1:0] rnd_w;
	fix_t                      accel_q_s3;

	// Stage 2: product
	always_ff @(posedge clk) begin
		if (ld_s2) begin
			prod_s2 <= APROD_W'(raw_s1) * $signed({1'b0, scale});
		end
	end

	assign rnd_w = (prod_s2 + AC_HALF) >>> AC_SHIFT;

	// Stage 3: rounded and clamped
	always_ff @(posedge clk) begin
		if (ld_s3) begin
			accel_q_s3 <= sat32(SAT_IN_W'(rnd_w));
		end
	end

	assign accel_s3 = accel_q_s3;

endmodule

// File: hdl/imu_sample_bias_deadband_conditioner.sv
// ----------------------------------------------------------------------------
// imu_sample_bias_deadband_conditioner
// Conditions one IMU sample per transfer: gyro bias calibration and
// bias-corrected deadbanded rates, scaled accel, converted temperature.
// ----------------------------------------------------------------------------
//  channel | handshake          | payload
//  --------+--------------------+---------------------------------------------
//  input   | in_valid/in_stall  | mode, id_byte, gyro_x..z, accel_x..z,
//          |                    | temp_high, temp_low
//  output  | out_valid/out_stall| rate_x..z, accel_out_x..z, temperature,
//          |                    | rates_fresh, calibration_done
//  config  | APB psel/penable   | paddr, pwdata, prdata (pready tied high)
//
//  One sample per cycle sustained while out_stall is low; three stages:
//  capture/bias subtract and calibration update, one multiplier per lane,
//  round/clamp/deadband into the output register. Reset clears the
//  pipeline, calibration sums, bias, held rates and loads register
//  defaults. A stalled output holds; earlier stages keep filling bubbles,
//  so in_stall rises only when every stage is occupied.
// ----------------------------------------------------------------------------
module imu_sample_bias_deadband_conditioner (
	input  logic                         clk,
	input  logic                         arst_n,
	// configuration
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [isbdc_pkg::ADDR_W-1:0] paddr,
	input  logic [isbdc_pkg::DATA_W-1:0] pwdata,
	output logic [isbdc_pkg::DATA_W-1:0] prdata,
	output logic                         pready,
	// input samples
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         mode,
	input  logic [7:0]                   id_byte,
	input  logic signed [15:0]           gyro_x,
	input  logic signed [15:0]           gyro_y,
	input  logic signed [15:0]           gyro_z,
	input  logic signed [15:0]           accel_x,
	input  logic signed [15:0]           accel_y,
	input  logic signed [15:0]           accel_z,
	input  logic [7:0]                   temp_high,
	input  logic [7:0]                   temp_low,
	// results
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic signed [31:0]           rate_x,
	output logic signed [31:0]           rate_y,
	output logic signed [31:0]           rate_z,
	output logic signed [31:0]           accel_out_x,
	output logic signed [31:0]           accel_out_y,
	output logic signed [31:0]           accel_out_z,
	output logic signed [31:0]           temperature,
	output logic                         rates_fresh,
	output logic                         calibration_done
);
	import isbdc_pkg::*;

	cfg_t  cfg;
	raw_t  gyro_in  [NAXES];
	raw_t  accel_in [NAXES];
	bias_t bias     [NAXES];
	logic  cal_take;
	logic  cal_done;
	logic  accept;

	// pipeline control
	logic  v1_q, v2_q, v3_q;
	logic  ld_s2, ld_s3;
	logic  rdy1, rdy2;

	// stage payloads
	diff_t                          diff_s1  [NAXES];
	raw_t                           accel_s1 [NAXES];
	logic signed [TRAW_W-1:0]       traw_s1;
	logic                           fresh_s1, done_s1;
	logic                           fresh_s2, done_s2;
	logic                           fresh_s3, done_s3;
	logic signed [TPROD_W-1:0]      tprod_s2;
	fix_t                           temp_s3;
	fix_t                           rate_s3  [NAXES];
	fix_t                           accel_s3 [NAXES];

	assign pready = 1'b1;

	assign gyro_in[0]  = gyro_x;
	assign gyro_in[1]  = gyro_y;
	assign gyro_in[2]  = gyro_z;
	assign accel_in[0] = accel_x;
	assign accel_in[1] = accel_y;
	assign accel_in[2] = accel_z;

	isbdc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	// Stage advance: each stage moves when the next one is empty or moving
	assign ld_s3    = v2_q && (!v3_q || !out_stall);
	assign rdy2     = !v2_q || ld_s3;
	assign ld_s2    = v1_q && rdy2;
	assign rdy1     = !v1_q || ld_s2;
	assign in_stall = !rdy1;
	assign accept   = in_valid && rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
		end else begin
			if (accept) begin
				v1_q <= 1'b1;
			end else if (ld_s2) begin
				v1_q <= 1'b0;
			end
			if (ld_s2) begin
				v2_q <= 1'b1;
			end else if (ld_s3) begin
				v2_q <= 1'b0;
			end
			if (ld_s3) begin
				v3_q <= 1'b1;
			end else if (!out_stall) begin
				v3_q <= 1'b0;
			end
		end
	end

	// Calibration runs on the transfer itself, so bias order follows input order
	assign cal_take = accept && mode;

	isbdc_cal u_cal (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (cal_take),
		.gyro   (gyro_in),
		.bias   (bias),
		.done   (cal_done)
	);

	// Stage 1: bias subtract, flags, temperature count
	always_ff @(posedge clk) begin
		if (accept) begin
			for (int i = 0; i < NAXES; i++) begin
				diff_s1[i]  <= D_W'($signed({gyro_in[i], 8'b0})) - D_W'(bias[i]);
				accel_s1[i] <= accel_in[i];
			end
			traw_s1  <= {temp_high, temp_low[7:5]};
			fresh_s1 <= !mode && (id_byte == cfg.expected_id);
			done_s1  <= cal_done;
		end
	end

	// Stage 2/3 lanes
	for (genvar g = 0; g < NAXES; g++) begin : g_lane
		isbdc_gyro_lane u_gyro (
			.clk      (clk),
			.arst_n   (arst_n),
			.ld_s2    (ld_s2),
			.ld_s3    (ld_s3),
			.diff_s1  (diff_s1[g]),
			.scale    (cfg.gyro_scale),
			.deadband (cfg.rate_deadband),
			.fresh_s2 (fresh_s2),
			.rate_s3  (rate_s3[g])
		);

		isbdc_accel_lane u_accel (
			.clk      (clk),
			.ld_s2    (ld_s2),
			.ld_s3    (ld_s3),
			.raw_s1   (accel_s1[g]),
			.scale    (cfg.accel_scale),
			.accel_s3 (accel_s3[g])
		);
	end

	// Temperature product and flags, stage 2
	always_ff @(posedge clk) begin
		if (ld_s2) begin
			tprod_s2 <= TPROD_W'(traw_s1) * $signed({1'b0, cfg.temp_factor});
			fresh_s2 <= fresh_s1;
			done_s2  <= done_s1;
		end
	end

	// Temperature offset and flags, stage 3
	always_ff @(posedge clk) begin
		if (ld_s3) begin
			temp_s3  <= sat32(SAT_IN_W'(tprod_s2) + SAT_IN_W'(cfg.temp_offset));
			fresh_s3 <= fresh_s2;
			done_s3  <= done_s2;
		end
	end

	// Result ports
	assign out_valid        = v3_q;
	assign rate_x           = rate_s3[0];
	assign rate_y           = rate_s3[1];
	assign rate_z           = rate_s3[2];
	assign accel_out_x      = accel_s3[0];
	assign accel_out_y      = accel_s3[1];
	assign accel_out_z      = accel_s3[2];
	assign temperature      = temp_s3;
	assign rates_fresh      = fresh_s3;
	assign calibration_done = done_s3;

endmodule

// File: tb/sv/isbdc_result_monitor.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// isbdc_result_monitor
// Watches the config port and both sample channels of the IMU conditioner.
// Keeps its own copy of the registers, bias and calibration state, predicts
// each conditioned sample on input transfer and compares output transfers
// in order, field by field.
// ----------------------------------------------------------------------------
module isbdc_result_monitor (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [isbdc_pkg::ADDR_W-1:0] paddr,
	input  logic [isbdc_pkg::DATA_W-1:0] pwdata,
	input  logic                         pready,
	input  logic                         in_valid,
	input  logic                         in_stall,
	input  logic                         mode,
	input  logic [7:0]                   id_byte,
	input  logic signed [15:0]           gyro_x,
	input  logic signed [15:0]           gyro_y,
	input  logic signed [15:0]           gyro_z,
	input  logic signed [15:0]           accel_x,
	input  logic signed [15:0]           accel_y,
	input  logic signed [15:0]           accel_z,
	input  logic [7:0]                   temp_high,
	input  logic [7:0]                   temp_low,
	input  logic                         out_valid,
	input  logic                         out_stall,
	input  logic signed [31:0]           rate_x,
	input  logic signed [31:0]           rate_y,
	input  logic signed [31:0]           rate_z,
	input  logic signed [31:0]           accel_out_x,
	input  logic signed [31:0]           accel_out_y,
	input  logic signed [31:0]           accel_out_z,
	input  logic signed [31:0]           temperature,
	input  logic                         rates_fresh,
	input  logic                         calibration_done,
	output int                           mismatches,
	output int                           pending
);
	import isbdc_pkg::*;

	localparam longint FIX_MAX = 2147483647;
	localparam longint FIX_MIN = -FIX_MAX - 1;
	localparam int     MAX_PRINTED = 100;

	typedef struct packed {
		logic [2:0][31:0] rate;
		logic [2:0][31:0] accel;
		logic [31:0]      temperature;
		logic             fresh;
		logic             cal_done;
	} conditioned_t;

	// register copy
	logic [SCALE_W-1:0]       gyro_gain;
	logic [SCALE_W-1:0]       accel_gain;
	logic [DB_W-1:0]          dead_zone;
	logic [TFAC_W-1:0]        temp_gain;
	logic signed [TOFS_W-1:0] temp_bias;
	logic [ID_W-1:0]          valid_id;

	// calibration and rate state
	logic signed [BIAS_W-1:0] axis_bias [NAXES];
	logic signed [SUM_W-1:0]  axis_sum [NAXES];
	logic signed [OUT_W-1:0]  last_rate [NAXES];
	int                       cal_taken;

	conditioned_t conditioned_q [$];
	conditioned_t want;

	function automatic logic signed [31:0] clamp32(input longint v);
		if (v > FIX_MAX) return FIX_MAX[31:0];
		if (v < FIX_MIN) return FIX_MIN[31:0];
		return 32'(v);
	endfunction

	// round half up, then floor shift
	function automatic longint round_shr(input longint v, input int sh);
		return (v + (longint'(1) <<< (sh - 1))) >>> sh;
	endfunction

	// next conditioned sample; updates calibration and held rates
	function automatic conditioned_t condition_sample(input logic cal_mode,
			input logic [7:0] id, input logic [2:0][15:0] gyro_raw,
			input logic [2:0][15:0] accel_raw, input logic [7:0] t_high,
			input logic [7:0] t_low);
		conditioned_t res;
		logic signed [TRAW_W-1:0] t_count;
		longint diff;
		longint rate;
		res.fresh = 1'b0;
		res.cal_done = 1'b0;
		for (int i = 0; i < NAXES; i++) begin
			res.accel[i] = clamp32(round_shr(longint'(signed'(accel_raw[i]))
				* longint'(accel_gain), AC_SHIFT));
			res.rate[i] = last_rate[i];
		end
		// 11-bit two's complement count
		t_count = {t_high, t_low[7:5]};
		res.temperature = clamp32(longint'(t_count) * longint'(temp_gain)
			+ longint'(temp_bias));
		if (cal_mode) begin
			for (int i = 0; i < NAXES; i++)
				axis_sum[i] = SUM_W'(longint'(axis_sum[i]) + longint'(signed'(gyro_raw[i])));
			cal_taken++;
			if (cal_taken >= CAL_SAMPLES) begin
				// mean as Q16.8, floor division by a power of two
				for (int i = 0; i < NAXES; i++) begin
					axis_bias[i] = BIAS_W'((longint'(axis_sum[i]) * 256) >>> CAL_LOG2);
					axis_sum[i] = '0;
				end
				cal_taken = 0;
				res.cal_done = 1'b1;
			end
		end else if (id == valid_id) begin
			for (int i = 0; i < NAXES; i++) begin
				diff = longint'(signed'(gyro_raw[i])) * 256 - longint'(axis_bias[i]);
				rate = longint'(clamp32(round_shr(diff * longint'(gyro_gain), GY_SHIFT)));
				if (rate < longint'(dead_zone) && rate > -longint'(dead_zone))
					rate = 0;
				last_rate[i] = 32'(rate);
				res.rate[i] = 32'(rate);
			end
			res.fresh = 1'b1;
		end
		return res;
	endfunction

	task automatic report(input string what, input logic [31:0] exp_val,
			input logic [31:0] got_val);
		mismatches++;
		if (mismatches <= MAX_PRINTED)
			$display("%0t ns: %s: expected %h, got %h", $time, what, exp_val, got_val);
	endtask

	task automatic check_field(input string what, input logic [31:0] exp_val,
			input logic [31:0] got_val);
		if (exp_val !== got_val)
			report(what, exp_val, got_val);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gyro_gain = GYRO_SCALE_RST;
			accel_gain = ACCEL_SCALE_RST;
			dead_zone = RATE_DB_RST;
			temp_gain = TEMP_FACTOR_RST;
			temp_bias = TEMP_OFFSET_RST;
			valid_id = EXPECTED_ID_RST;
			for (int i = 0; i < NAXES; i++) begin
				axis_bias[i] = '0;
				axis_sum[i] = '0;
				last_rate[i] = '0;
			end
			cal_taken = 0;
			mismatches = 0;
			conditioned_q.delete();
			pending <= 0;
		end else begin
			// register write on the access cycle; unknown slots ignored
			if (psel && penable && pwrite && pready) begin
				case (paddr[ADDR_W-1:2])
					REG_GYRO_SCALE:  gyro_gain = pwdata[SCALE_W-1:0];
					REG_ACCEL_SCALE: accel_gain = pwdata[SCALE_W-1:0];
					REG_RATE_DB:     dead_zone = pwdata[DB_W-1:0];
					REG_TEMP_FACTOR: temp_gain = pwdata[TFAC_W-1:0];
					REG_TEMP_OFFSET: temp_bias = pwdata[TOFS_W-1:0];
					REG_EXPECTED_ID: valid_id = pwdata[ID_W-1:0];
					default: ;
				endcase
			end

			// input transfer
			if (in_valid && !in_stall)
				conditioned_q.push_back(condition_sample(mode, id_byte,
					{gyro_z, gyro_y, gyro_x}, {accel_z, accel_y, accel_x},
					temp_high, temp_low));

			// output transfer
			if (out_valid && !out_stall) begin
				if (conditioned_q.size() == 0) begin
					report("result with nothing expected", '0, rate_x);
				end else begin
					want = conditioned_q.pop_front();
					check_field("rate_x", want.rate[0], rate_x);
					check_field("rate_y", want.rate[1], rate_y);
					check_field("rate_z", want.rate[2], rate_z);
					check_field("accel_out_x", want.accel[0], accel_out_x);
					check_field("accel_out_y", want.accel[1], accel_out_y);
					check_field("accel_out_z", want.accel[2], accel_out_z);
					check_field("temperature", want.temperature, temperature);
					check_field("rates_fresh", 32'(want.fresh), 32'(rates_fresh));
					check_field("calibration_done", 32'(want.cal_done),
						32'(calibration_done));
				end
			end
			pending <= conditioned_q.size();
		end
	end

endmodule

// File: tb/sv/imu_sample_bias_deadband_conditioner_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// imu_sample_bias_deadband_conditioner_tb
// Drives the IMU conditioner with a directed set of edge samples, then
// random phases with new register settings and mixed measure/calibration
// traffic under random idle and stall bursts.
// Checking is done by the result monitor; this module gives the verdict.
// ----------------------------------------------------------------------------
module imu_sample_bias_deadband_conditioner_tb;
	import isbdc_pkg::*;

	localparam logic [2:0] REG_SPARE       = 3'd6;	// unmapped slot
	localparam int         RANDOM_PHASES   = 6;
	localparam int         MIXED_PER_PHASE = 90;

	typedef struct packed {
		logic             mode;
		logic [7:0]       id;
		logic [2:0][15:0] gyro;
		logic [2:0][15:0] accel;
		logic [7:0]       t_high;
		logic [7:0]       t_low;
	} imu_sample_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [ADDR_W-1:0]  paddr;
	logic [DATA_W-1:0]  pwdata;
	logic [DATA_W-1:0]  prdata;
	logic               pready;
	logic               in_valid;
	logic               in_stall;
	logic               mode;
	logic [7:0]         id_byte;
	logic signed [15:0] gyro_x;
	logic signed [15:0] gyro_y;
	logic signed [15:0] gyro_z;
	logic signed [15:0] accel_x;
	logic signed [15:0] accel_y;
	logic signed [15:0] accel_z;
	logic [7:0]         temp_high;
	logic [7:0]         temp_low;
	logic               out_valid;
	logic               out_stall;
	logic signed [31:0] rate_x;
	logic signed [31:0] rate_y;
	logic signed [31:0] rate_z;
	logic signed [31:0] accel_out_x;
	logic signed [31:0] accel_out_y;
	logic signed [31:0] accel_out_z;
	logic signed [31:0] temperature;
	logic               rates_fresh;
	logic               calibration_done;
	int                 mismatches;
	int                 pending;

	// stimulus state
	logic               calm = 1'b0;
	int                 idle_odds = 4;
	logic [7:0]         live_id = EXPECTED_ID_RST;

	imu_sample_bias_deadband_conditioner uut (.*);
	isbdc_result_monitor result_monitor (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// hard limit
	initial begin
		#5_000_000;
		$display("FAIL");
		$finish;
	end

	// output stall bursts, with quiet stretches
	initial begin
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (!calm && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 8)) @(posedge clk);
				out_stall <= 1'b0;
			end else if ($urandom_range(0, 15) == 0) begin
				repeat ($urandom_range(20, 60)) @(posedge clk);
			end
		end
	end

	function automatic imu_sample_t pack_sample(input logic m, input logic [7:0] id,
			input logic [15:0] gx, gy, gz, ax, ay, az, input logic [7:0] th, tl);
		imu_sample_t s;
		s.mode = m;
		s.id = id;
		s.gyro = {gz, gy, gx};
		s.accel = {az, ay, ax};
		s.t_high = th;
		s.t_low = tl;
		return s;
	endfunction

	// raw count: extremes, values near zero, or anything
	function automatic logic [15:0] rand_count();
		case ($urandom_range(0, 7))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2, 3: return 16'($urandom_range(0, 2000)) - 16'd1000;
			default: return 16'($urandom);
		endcase
	endfunction

	// mostly matching measure samples, some calibration, some bad id
	function automatic imu_sample_t rand_sample();
		imu_sample_t s;
		int pick;
		pick = $urandom_range(0, 9);
		s.mode = (pick < 2);
		s.id = (pick == 2) ? live_id ^ 8'($urandom_range(1, 255)) : live_id;
		if (s.mode && $urandom_range(0, 1) == 0)
			s.id = 8'($urandom);
		for (int i = 0; i < NAXES; i++) begin
			s.gyro[i] = rand_count();
			s.accel[i] = rand_count();
		end
		s.t_high = 8'($urandom);
		s.t_low = 8'($urandom);
		return s;
	endfunction

	// one input transfer, then maybe an idle burst
	task automatic send(input imu_sample_t s);
		in_valid <= 1'b1;
		mode <= s.mode;
		id_byte <= s.id;
		gyro_x <= s.gyro[0];
		gyro_y <= s.gyro[1];
		gyro_z <= s.gyro[2];
		accel_x <= s.accel[0];
		accel_y <= s.accel[1];
		accel_z <= s.accel[2];
		temp_high <= s.t_high;
		temp_low <= s.t_low;
		do @(posedge clk); while (in_stall);
		if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	endtask

	// APB write: setup cycle, then access cycle
	task automatic cfg_write(input logic [2:0] slot, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'({slot, 2'b00});
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		if (slot == REG_EXPECTED_ID)
			live_id = value[7:0];
	endtask

	// stop sending, then wait until every transfer has come out
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic randomize_config();
		case ($urandom_range(0, 5))
			0: cfg_write(REG_GYRO_SCALE, 32'h0);
			1: cfg_write(REG_GYRO_SCALE, 32'hFFFF_FFFF);
			default: cfg_write(REG_GYRO_SCALE, $urandom_range(32'h0001_0000, 32'h0100_0000));
		endcase
		case ($urandom_range(0, 5))
			0: cfg_write(REG_ACCEL_SCALE, 32'h0);
			1: cfg_write(REG_ACCEL_SCALE, 32'hFFFF_FFFF);
			default: cfg_write(REG_ACCEL_SCALE, $urandom_range(32'h0001_0000, 32'h0100_0000));
		endcase
		case ($urandom_range(0, 5))
			0: cfg_write(REG_RATE_DB, 32'h0);
			1: cfg_write(REG_RATE_DB, 32'h7FFF_FFFF);
			default: cfg_write(REG_RATE_DB, $urandom_range(0, 32'h0008_0000));
		endcase
		case ($urandom_range(0, 5))
			0: cfg_write(REG_TEMP_FACTOR, 32'h0);
			1: cfg_write(REG_TEMP_FACTOR, 32'h00FF_FFFF);
			default: cfg_write(REG_TEMP_FACTOR, $urandom_range(0, 32'h0000_FFFF));
		endcase
		case ($urandom_range(0, 5))
			0: cfg_write(REG_TEMP_OFFSET, 32'h0080_0000);
			1: cfg_write(REG_TEMP_OFFSET, 32'h007F_FFFF);
			default: cfg_write(REG_TEMP_OFFSET, $urandom & 32'h00FF_FFFF);
		endcase
		cfg_write(REG_EXPECTED_ID, $urandom_range(0, 255));
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		mode = 1'b0;
		id_byte = '0;
		gyro_x = '0;
		gyro_y = '0;
		gyro_z = '0;
		accel_x = '0;
		accel_y = '0;
		accel_z = '0;
		temp_high = '0;
		temp_low = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// defaults: zero input, count extremes, temperature count +1023 / -1024 / -1
		send(pack_sample(1'b0, 8'd15, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 8'h00, 8'h00));
		send(pack_sample(1'b0, 8'd15, 16'h7FFF, 16'h8000, 16'h0001,
			16'h7FFF, 16'h8000, 16'hFFFF, 8'h7F, 8'hE0));
		send(pack_sample(1'b0, 8'd15, 16'h8000, 16'h7FFF, 16'hFFFF,
			16'h8000, 16'h7FFF, 16'h0001, 8'h80, 8'h1F));
		// id mismatch holds rates; calibration sample holds rates too
		send(pack_sample(1'b0, 8'hF0, 16'h1234, 16'h4321, 16'hABCD,
			16'h0100, 16'hFF00, 16'h0000, 8'h12, 8'h40));
		send(pack_sample(1'b1, 8'd15, 16'h0100, 16'hFF00, 16'h0000,
			16'h5555, 16'hAAAA, 16'h0FF0, 8'hFF, 8'hFF));

		// widest products saturate
		wait_drained();
		cfg_write(REG_GYRO_SCALE, 32'hFFFF_FFFF);
		cfg_write(REG_ACCEL_SCALE, 32'hFFFF_FFFF);
		cfg_write(REG_TEMP_FACTOR, 32'h00FF_FFFF);
		cfg_write(REG_TEMP_OFFSET, 32'h007F_FFFF);
		send(pack_sample(1'b0, 8'd15, 16'h7FFF, 16'h8000, 16'h0000,
			16'h7FFF, 16'h8000, 16'h0000, 8'h7F, 8'hE0));
		send(pack_sample(1'b0, 8'd15, 16'h8000, 16'h7FFF, 16'h0000,
			16'h8000, 16'h7FFF, 16'h0000, 8'h80, 8'h00));

		// zero scales, widest deadband, id zero
		wait_drained();
		cfg_write(REG_TEMP_OFFSET, 32'h0080_0000);
		cfg_write(REG_GYRO_SCALE, 32'h0);
		cfg_write(REG_ACCEL_SCALE, 32'h0);
		cfg_write(REG_RATE_DB, 32'h7FFF_FFFF);
		cfg_write(REG_EXPECTED_ID, 32'h0);
		send(pack_sample(1'b0, 8'h00, 16'h7FFF, 16'h8000, 16'h0001,
			16'h7FFF, 16'h8000, 16'h0001, 8'h80, 8'h00));
		send(pack_sample(1'b0, 8'd15, 16'h7FFF, 16'h8000, 16'h0001,
			16'h7FFF, 16'h8000, 16'h0001, 8'h00, 8'h00));

		// saturated rates survive the widest deadband, small ones do not
		wait_drained();
		cfg_write(REG_GYRO_SCALE, 32'hFFFF_FFFF);
		send(pack_sample(1'b0, 8'h00, 16'h7FFF, 16'h8000, 16'h0001,
			16'h0000, 16'h0000, 16'h0000, 8'h01, 8'h20));

		// deadband of 1.0 around its threshold; unmapped slot is ignored
		wait_drained();
		cfg_write(REG_GYRO_SCALE, GYRO_SCALE_RST);
		cfg_write(REG_ACCEL_SCALE, ACCEL_SCALE_RST);
		cfg_write(REG_RATE_DB, 32'h0001_0000);
		cfg_write(REG_TEMP_FACTOR, 32'(TEMP_FACTOR_RST));
		cfg_write(REG_TEMP_OFFSET, 32'(TEMP_OFFSET_RST));
		cfg_write(REG_EXPECTED_ID, 32'hFF);
		cfg_write(REG_SPARE, 32'hDEAD_BEEF);
		send(pack_sample(1'b0, 8'hFF, 16'h03AA, 16'hFC56, 16'h03AB,
			16'h0001, 16'hFFFF, 16'h0000, 8'h20, 8'hA0));
		send(pack_sample(1'b0, 8'hFF, 16'hFC55, 16'h0000, 16'h7FFF,
			16'h0002, 16'hFFFE, 16'h0003, 8'hE0, 8'h60));

		// random phases; the last one runs without idling
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			wait_drained();
			calm <= (p == RANDOM_PHASES - 1);
			idle_odds = (p == RANDOM_PHASES - 1) ? 0 : $urandom_range(0, 4);
			randomize_config();
			repeat (MIXED_PER_PHASE) send(rand_sample());
		end
		in_valid <= 1'b0;
		wait_drained();
		repeat (10) @(posedge clk);

		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
